// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, including while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/gmcp_pkg.sv
`default_nettype none
package gmcp_pkg;

    localparam int COST_W = 16;
    localparam int SUM_W  = 48;
    localparam int DIM_W  = 11;

    typedef logic signed [COST_W-1:0] cost_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic        [DIM_W-1:0]  dim_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_idx_t;

endpackage
`default_nettype wire

// File: sv/gmcp_if.sv
`default_nettype none
// Input cell stream.
interface gmcp_cell_if;
    logic            valid;
    logic            ready;
    gmcp_pkg::cost_t cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

// Result stream.
interface gmcp_result_if;
    logic           valid;
    logic           ready;
    gmcp_pkg::sum_t total_cost;

    modport source (output valid, output total_cost, input ready);
    modport sink   (input valid, input total_cost, output ready);
endinterface

// Configuration write channel.
interface gmcp_cfg_if;
    logic               valid;
    logic               ready;
    gmcp_pkg::cfg_idx_t index;
    gmcp_pkg::dim_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/grid_min_cost_path.sv
// The result beat is registered: the last cell of a matrix passes stage 1, then the output register.
// Throughput: one cell per cycle, limited by the single read and write port of the row buffer,
// except while a stalled result holds back the next last cell, which then blocks the input.
// Reset (rst_n low, asynchronous) clears the position, the left and diagonal sums,
// the pipeline valids and sets both dimensions to one. The row buffer is not cleared.
`default_nettype none
`include "assert_macros.svh"

module grid_min_cost_path #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    gmcp_cell_if.sink      cells,
    gmcp_result_if.source  result,
    gmcp_cfg_if.sink       cfg
);
    import gmcp_pkg::*;

    // Column and row counters only need to reach the largest index.
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // ------------------------------------------------------------------
    // Configuration. The port is always ready. Any write restarts the
    // sweep at the first cell of a new matrix.
    // ------------------------------------------------------------------
    dim_t num_rows_reg;
    dim_t num_cols_reg;
    logic cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= dim_t'(1);
            num_cols_reg <= dim_t'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                REG_NUM_ROWS: num_rows_reg <= cfg.data;
                REG_NUM_COLS: num_cols_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // Index of the last row and column. A dimension of zero acts as one,
    // and a dimension above the maximum acts as the maximum.
    logic [CW-1:0] cols_last;
    logic [RW-1:0] rows_last;

    always_comb
    begin
        if (num_cols_reg == '0)
            cols_last = '0;
        else if (32'(num_cols_reg) > MAX_COLS)
            cols_last = CW'(MAX_COLS - 1);
        else
            cols_last = CW'(num_cols_reg - dim_t'(1));

        if (num_rows_reg == '0)
            rows_last = '0;
        else if (32'(num_rows_reg) > MAX_ROWS)
            rows_last = RW'(MAX_ROWS - 1);
        else
            rows_last = RW'(num_rows_reg - dim_t'(1));
    end

    // ------------------------------------------------------------------
    // Stage 0: accept a cell, track its position and issue the read of the
    // best sum above it from the row buffer.
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          accept;
    logic          cell_last;

    // Stage 1 registers.
    logic          s1_valid_reg;
    cost_t         s1_cost_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_first_row_reg;
    logic          s1_first_col_reg;
    logic          s1_last_reg;
    logic          s1_fwd_reg;
    logic          s1_advance;

    // Output register.
    logic          out_valid_reg;
    sum_t          out_cost_reg;

    assign accept    = cells.valid && cells.ready;
    assign cell_last = (row_reg == rows_last) && (col_reg == cols_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (cell_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == cols_last)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Row buffer: one entry per column holding the best sum of the row
    // above. One read port (registered data, read on accept so that the
    // data holds while stage 1 stalls) and one write port from stage 1.
    // ------------------------------------------------------------------
    sum_t          row_sums_mem [MAX_COLS];
    sum_t          up_rd_reg;
    logic          mem_we;
    sum_t          sum_value;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_sums_mem[s1_col_reg] <= sum_value;
        if (accept)
            up_rd_reg <= row_sums_mem[col_reg];
    end

    // ------------------------------------------------------------------
    // Stage 1: add the cell cost to the smallest neighbor sum and write the
    // result back. With a single column the cell above is the one stage 1
    // finishes in the same cycle as the read, so the read returns stale
    // data; that case is flagged at accept and the sum is taken from the
    // left register, which holds exactly that finished sum.
    // ------------------------------------------------------------------
    sum_t left_sum_reg;
    sum_t diag_sum_reg;
    sum_t up_value;
    sum_t best_nb;
    sum_t min_ud;

    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign cells.ready = !s1_valid_reg || s1_advance;
    assign mem_we = s1_advance;

    always_comb
    begin
        if (s1_first_row_reg)
            up_value = '0;
        else if (s1_fwd_reg)
            up_value = left_sum_reg;
        else
            up_value = up_rd_reg;

        min_ud = (up_value < diag_sum_reg) ? up_value : diag_sum_reg;

        if (s1_first_row_reg && s1_first_col_reg)
            best_nb = '0;
        else if (s1_first_row_reg)
            best_nb = left_sum_reg;
        else if (s1_first_col_reg)
            best_nb = up_value;
        else
            best_nb = (left_sum_reg < min_ud) ? left_sum_reg : min_ud;

        sum_value = SUM_W'(s1_cost_reg) + best_nb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cells.ready)
            s1_valid_reg <= cells.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cost_reg      <= cells.cell_cost;
            s1_col_reg       <= col_reg;
            s1_first_row_reg <= (row_reg == '0);
            s1_first_col_reg <= (col_reg == '0);
            s1_last_reg      <= cell_last;
            // Stage 1 writes the same entry in this cycle: forward it.
            s1_fwd_reg       <= s1_advance && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sum_reg <= '0;
            diag_sum_reg <= '0;
        end
        else if (cfg_wr)
        begin
            left_sum_reg <= '0;
            diag_sum_reg <= '0;
        end
        else if (s1_advance)
        begin
            left_sum_reg <= s1_last_reg ? '0 : sum_value;
            diag_sum_reg <= s1_last_reg ? '0 : up_value;
        end
    end

    // ------------------------------------------------------------------
    // Output register: one result beat per matrix, taken from the last cell.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
            out_cost_reg <= sum_value;
    end

    assign result.valid      = out_valid_reg;
    assign result.total_cost = out_cost_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_fwd_single_col, clk, rst_n,
        (s1_valid_reg && s1_fwd_reg && !s1_first_row_reg) |-> (cols_last == '0),
        "forwarding used with more than one column")
    `ASSERT_CLK(a_col_in_range, clk, rst_n,
        (col_reg <= cols_last) && (row_reg <= rows_last),
        "position counter beyond matrix size")
    `ASSERT_CLK(a_last_not_dropped, clk, rst_n,
        (s1_valid_reg && s1_last_reg && cells.ready) |-> (!result.valid || result.ready),
        "last cell advanced over a pending result")
    `ASSERT_ALWAYS(a_reset_clear, clk,
        !rst_n |-> (!s1_valid_reg && !out_valid_reg),
        "pipeline valid set during reset")

endmodule
`default_nettype wire

// File: verif/grid_min_cost_path_tb.sv
module grid_min_cost_path_tb;
    import gmcp_pkg::*;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // The stimulus stops once both of these are reached. They are stop conditions only.
    localparam int ITEM_TARGET   = 1900;
    localparam int RESULT_TARGET = 40;

    // A result beat shows up once the last cell passes stage 1 and the output register.
    // The margin covers that and any cell still in the pipe when a register write is about to happen.
    localparam int DRAIN_CYCLES = 8;

    // The receiver holds off for this many cycles while the sender keeps offering cells.
    localparam int HOLD_CYCLES = 300;

    // The watchdog limit, well above the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;

    // One row of the directed table: either a register write or a single cell. A cell row
    // may carry a hand-written total that replaces the predicted one.
    typedef struct {
        bit       is_write;
        cfg_idx_t index;
        dim_t     data;
        cost_t    cost;
        bit       typed;
        sum_t     total;
    } plan_row_t;

    logic clk;
    logic rst_n;

    gmcp_cell_if   cell_bus ();
    gmcp_result_if res_bus ();
    gmcp_cfg_if    cfg_bus ();

    grid_min_cost_path #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cells (cell_bus),
        .result(res_bus),
        .cfg   (cfg_bus)
    );

    // These travel with each cell beat. They say whether the total that this beat
    // completes was typed into the directed table, and what that total is.
    bit   cell_typed;
    sum_t cell_typed_total;

    // The predictor's own copy of the block's state and registers.
    sum_t        row_buf [MAX_COLS];
    sum_t        left_sum;
    sum_t        diag_sum;
    int unsigned row_pos;
    int unsigned col_pos;
    dim_t        rows_reg;
    dim_t        cols_reg;

    // The totals that are predicted but not yet seen, oldest first.
    sum_t pending_totals [$];

    int mismatches;
    int cells_sent;
    int totals_seen;
    int cycle_count;

    // These are the idling knobs, in percent. The stimulus process sets them for each phase.
    int cell_idle_pct;
    int result_stall_pct;

    // A request for a long receiver hold-off. The receiver process counts it down by itself.
    int hold_asks;
    int hold_seen;
    int hold_left;

    // These are the register values that the stimulus process last wrote. They let it size
    // its matrices without looking at the predictor's copy.
    dim_t plan_rows;
    dim_t plan_cols;

    plan_row_t plan [$];

    // The clock has a period of 8 time units.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // A dimension register value of zero counts as one. A value above the maximum counts
    // as the maximum.
    function automatic int unsigned eff_dim(input dim_t value, input int unsigned limit);
        if (value == '0)
            return 1;
        if (value > limit)
            return limit;
        return 32'(value);
    endfunction

    function automatic void restart_sweep();
        row_pos  = 0;
        col_pos  = 0;
        left_sum = '0;
        diag_sum = '0;
    endfunction

    // This advances the path sums by one cell in raster order. It returns 1 when the cell
    // is the last one of the matrix, and then best_total holds the minimum path cost.
    function automatic bit advance_path_sums(input cost_t cost, output sum_t best_total);
        int unsigned n_rows;
        int unsigned n_cols;
        int unsigned r;
        int unsigned c;
        sum_t        up;
        sum_t        best;
        sum_t        low;
        n_rows = eff_dim(rows_reg, MAX_ROWS);
        n_cols = eff_dim(cols_reg, MAX_COLS);
        r = row_pos;
        c = col_pos;
        if (c >= n_cols || r >= n_rows)
        begin
            r = 0;
            c = 0;
        end
        up = '0;
        if (r != 0)
            up = row_buf[c];
        if (r == 0 && c == 0)
            best = sum_t'(cost);
        else if (r == 0)
            best = left_sum + sum_t'(cost);
        else if (c == 0)
            best = up + sum_t'(cost);
        else
        begin
            // Cells inside the matrix take the cheapest of the left, upper and
            // upper-left neighbors.
            low = (up < diag_sum) ? up : diag_sum;
            if (left_sum < low)
                low = left_sum;
            best = low + sum_t'(cost);
        end
        diag_sum   = up;
        left_sum   = best;
        row_buf[c] = best;
        best_total = best;
        if (r == n_rows - 1 && c == n_cols - 1)
        begin
            restart_sweep();
            return 1'b1;
        end
        c++;
        if (c == n_cols)
        begin
            c = 0;
            r++;
        end
        row_pos = r;
        col_pos = c;
        return 1'b0;
    endfunction

    // Extreme costs come up often enough to stack into large sums.
    function automatic cost_t pick_cost();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return cost_t'($urandom);
        endcase
    endfunction

    function automatic plan_row_t cell_row(input cost_t cost, input bit typed, input sum_t total);
        plan_row_t row;
        row.is_write = 1'b0;
        row.index    = REG_NUM_ROWS;
        row.data     = '0;
        row.cost     = cost;
        row.typed    = typed;
        row.total    = total;
        return row;
    endfunction

    function automatic plan_row_t write_row(input cfg_idx_t index, input dim_t data);
        plan_row_t row;
        row.is_write = 1'b1;
        row.index    = index;
        row.data     = data;
        row.cost     = '0;
        row.typed    = 1'b0;
        row.total    = '0;
        return row;
    endfunction

    // This offers one cell beat, with random idle cycles ahead of it, and returns at the
    // clock edge where the beat is taken. The valid stays high afterward, so the next
    // call can follow it without a gap. It also takes down the valid that a register
    // write left high before it.
    task automatic send_cell(input cost_t cost, input bit typed, input sum_t total);
        cfg_bus.valid <= 1'b0;
        while ($urandom_range(99) < cell_idle_pct)
        begin
            cell_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cell_bus.valid     <= 1'b1;
        cell_bus.cell_cost <= cost;
        cell_typed         <= typed;
        cell_typed_total   <= total;
        do
            @(posedge clk);
        while (!cell_bus.ready);
        cells_sent++;
    endtask

    // This takes both input channels quiet. It then waits until every predicted total has
    // come back, plus a margin for a cell that finishes no matrix but may still be in flight.
    task automatic wait_for_idle();
        cell_bus.valid <= 1'b0;
        cfg_bus.valid  <= 1'b0;
        @(posedge clk);
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // This is one register write beat. The valid is left high, and the next cell or the
    // next idle wait takes it down, so that two writes in a row can follow each other.
    task automatic write_reg(input cfg_idx_t index, input dim_t data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (index == REG_NUM_ROWS)
            plan_rows = data;
        else
            plan_cols = data;
    endtask

    // Result receiver. Each cycle it drops ready at the phase's stall rate. A hold-off
    // request keeps it low for a long count of cycles, and that lets the block fill up.
    initial
    begin
        res_bus.ready = 1'b0;
        hold_seen     = 0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= result_stall_pct);
        end
    end

    // Monitor. At each clock edge it looks at the pre-edge values of every channel. It
    // checks the result beats against the oldest prediction, passes register writes to
    // the predictor, and runs the predictor on each accepted cell.
    always @(posedge clk)
    begin : monitor
        sum_t want;
        sum_t got_total;
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (pending_totals.size() == 0)
                begin
                    $display("%0t: total_cost beat with nothing expected, expected none, got %0d",
                             $time, res_bus.total_cost);
                    mismatches++;
                end
                else
                begin
                    want = pending_totals.pop_front();
                    if (res_bus.total_cost !== want)
                    begin
                        $display("%0t: total_cost mismatch, expected %0d, got %0d",
                                 $time, want, res_bus.total_cost);
                        mismatches++;
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                // Any register write starts a new matrix.
                if (cfg_bus.index == REG_NUM_ROWS)
                    rows_reg = cfg_bus.data;
                else
                    cols_reg = cfg_bus.data;
                restart_sweep();
            end
            if (cell_bus.valid && cell_bus.ready)
            begin
                if (advance_path_sums(cell_bus.cell_cost, got_total))
                begin
                    pending_totals.push_back(cell_typed ? cell_typed_total : got_total);
                    totals_seen++;
                end
            end
        end
    end

    // This is the watchdog. If a run hangs, for example on a total that never arrives,
    // the run ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d totals outstanding", $time, pending_totals.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        int   ph;
        int   n_mat;
        int   n_cells;
        int   n_part;
        int   pick;
        bit   special;
        dim_t r_val;
        dim_t c_val;

        // Every input gets a known value from time zero. The predictor starts in its
        // reset state.
        rst_n              = 1'b0;
        cell_bus.valid     = 1'b0;
        cell_bus.cell_cost = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_NUM_ROWS;
        cfg_bus.data       = '0;
        cell_typed         = 1'b0;
        cell_typed_total   = '0;
        cell_idle_pct      = 0;
        result_stall_pct   = 0;
        hold_asks          = 0;
        mismatches         = 0;
        cells_sent         = 0;
        totals_seen        = 0;
        cycle_count        = 0;
        rows_reg           = dim_t'(1);
        cols_reg           = dim_t'(1);
        plan_rows          = dim_t'(1);
        plan_cols          = dim_t'(1);
        foreach (row_buf[i])
            row_buf[i] = '0;
        restart_sweep();

        // The directed table. Out of reset the matrix is one by one, so every cell is a
        // whole matrix and its cost is the total. A zero dimension counts as one, and a
        // run of equal extreme costs along a single line gives a plain multiple. The
        // three by three part breaks off one matrix with a register write partway
        // through, and then finishes a full one.
        plan.push_back(cell_row(16'sh7FFF, 1'b1, 32767));
        plan.push_back(cell_row(16'sh8000, 1'b1, -32768));
        plan.push_back(cell_row(16'sh0000, 1'b1, 0));
        plan.push_back(cell_row(16'shFFFF, 1'b1, -1));
        plan.push_back(write_row(REG_NUM_ROWS, dim_t'(2)));
        plan.push_back(write_row(REG_NUM_COLS, dim_t'(2)));
        plan.push_back(cell_row(16'sd1, 1'b0, '0));
        plan.push_back(cell_row(16'sd2, 1'b0, '0));
        plan.push_back(cell_row(16'sd3, 1'b0, '0));
        plan.push_back(cell_row(16'sd4, 1'b0, '0));
        plan.push_back(write_row(REG_NUM_ROWS, dim_t'(0)));
        plan.push_back(write_row(REG_NUM_COLS, dim_t'(3)));
        plan.push_back(cell_row(16'sh7FFF, 1'b0, '0));
        plan.push_back(cell_row(16'sh7FFF, 1'b0, '0));
        plan.push_back(cell_row(16'sh7FFF, 1'b1, 98301));
        plan.push_back(write_row(REG_NUM_ROWS, dim_t'(3)));
        plan.push_back(write_row(REG_NUM_COLS, dim_t'(0)));
        plan.push_back(cell_row(16'sh8000, 1'b0, '0));
        plan.push_back(cell_row(16'sh8000, 1'b0, '0));
        plan.push_back(cell_row(16'sh8000, 1'b1, -98304));
        plan.push_back(write_row(REG_NUM_COLS, dim_t'(3)));
        plan.push_back(cell_row(16'sd5, 1'b0, '0));
        plan.push_back(cell_row(-16'sd7, 1'b0, '0));
        plan.push_back(write_row(REG_NUM_COLS, dim_t'(3)));
        plan.push_back(cell_row(16'sd3, 1'b0, '0));
        plan.push_back(cell_row(-16'sd2, 1'b0, '0));
        plan.push_back(cell_row(16'sd8, 1'b0, '0));
        plan.push_back(cell_row(-16'sd5, 1'b0, '0));
        plan.push_back(cell_row(16'sd1, 1'b0, '0));
        plan.push_back(cell_row(16'sd7, 1'b0, '0));
        plan.push_back(cell_row(-16'sd9, 1'b0, '0));
        plan.push_back(cell_row(16'sd4, 1'b0, '0));
        plan.push_back(cell_row(16'sd6, 1'b0, '0));

        // Reset is held low at the start and then released once.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (i == 0 || !plan[i - 1].is_write)
                    wait_for_idle();
                write_reg(plan[i].index, plan[i].data);
            end
            else
                send_cell(plan[i].cost, plan[i].typed, plan[i].total);
        end

        // Random phases. The idling pattern turns over from phase to phase. Most phases
        // send a few whole matrices of small random size, and some end with a matrix that
        // a register write breaks off. Phases 3 and 6 write all ones to one register, and
        // that is clamped to the full size. Phase 5 is a medium-sized matrix. In phase 8
        // the receiver holds off for a long time while short matrices keep coming.
        ph = 0;
        while (cells_sent < ITEM_TARGET || totals_seen < RESULT_TARGET)
        begin
            case (ph % 4)
                0: begin cell_idle_pct = 0;  result_stall_pct = 0;  end
                1: begin cell_idle_pct = 54; result_stall_pct = 0;  end
                2: begin cell_idle_pct = 0;  result_stall_pct = 54; end
                default: begin cell_idle_pct = 33; result_stall_pct = 33; end
            endcase

            special = 1'b1;
            if (ph == 3)
            begin
                r_val = '1;
                c_val = dim_t'(1);
            end
            else if (ph == 6)
            begin
                r_val = dim_t'(1);
                c_val = '1;
            end
            else if (ph == 8)
            begin
                r_val = dim_t'(1);
                c_val = dim_t'(2);
            end
            else if (ph == 5)
            begin
                r_val = dim_t'($urandom_range(6, 3));
                c_val = dim_t'($urandom_range(40, 16));
            end
            else
            begin
                special = 1'b0;
                r_val   = dim_t'($urandom_range(6, 0));
                c_val   = dim_t'($urandom_range(6, 0));
            end

            wait_for_idle();
            // Normal phases sometimes write only one register. The other one must keep
            // its value across the restart.
            pick = special ? 3 : $urandom_range(3);
            if (pick != 1)
                write_reg(REG_NUM_ROWS, r_val);
            if (pick != 0)
                write_reg(REG_NUM_COLS, c_val);

            n_cells = eff_dim(plan_rows, MAX_ROWS) * eff_dim(plan_cols, MAX_COLS);
            n_mat   = special ? 1 : $urandom_range(4, 1);

            if (ph == 8)
            begin
                // Each matrix is two cells long. A stalled total holds back the next last
                // cell, so the input backs up during the hold-off.
                cell_idle_pct    = 0;
                result_stall_pct = 0;
                n_mat            = 20;
                hold_asks++;
            end

            repeat (n_mat * n_cells)
                send_cell(pick_cost(), 1'b0, '0);

            if (!special && n_cells > 1 && $urandom_range(3) == 0)
            begin
                n_part = $urandom_range(n_cells - 1, 1);
                repeat (n_part)
                    send_cell(pick_cost(), 1'b0, '0);
            end
            ph++;
        end

        wait_for_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/gmcp_pkg.sv
sv/gmcp_if.sv
sv/grid_min_cost_path.sv
verif/grid_min_cost_path_tb.sv
